@@ rtl/core/piecewise_linear_envelope_top_defines.svh @@
// Assertion macros for the piecewise linear envelope block.
// Taken in by the top level; the assertions sample clk and are disabled while rst_n is low.
`ifndef PIECEWISE_LINEAR_ENVELOPE_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_ENVELOPE_TOP_DEFINES_SVH

// Same-cycle implication.
`define PLE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
// Shared widths and codes for the piecewise linear envelope block.
// No dependencies; used by the channel interfaces and the top level.
package ple_pkg;

    localparam int VAL_W  = 17;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd2;

    // Q1.16 unity
    localparam logic [VAL_W-1:0] UNIT_ONE = 17'h10000;

    // One quotient bit per step; the quotient never exceeds VAL_W bits
    localparam int DIV_STEPS = VAL_W;
    localparam int DIV_CNT_W = 5;

endpackage

@@ rtl/core/ple_channels.sv @@
// Valid/ready channel interfaces for the envelope block: command in, result out.
// Depends on ple_pkg for field widths.
interface ple_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ple_pkg::MODE_W-1:0]   mode;
    logic [ple_pkg::VAL_W-1:0]    position;
    logic [ple_pkg::VAL_W-1:0]    level;

    modport source (output valid, output mode, output position, output level, input ready);
    modport sink   (input valid, input mode, input position, input level, output ready);
endinterface

interface ple_res_if;
    logic                         valid;
    logic                         ready;
    logic [ple_pkg::VAL_W-1:0]    amplitude;
    logic                         knot_accepted;

    modport source (output valid, output amplitude, output knot_accepted, input ready);
    modport sink   (input valid, input amplitude, input knot_accepted, output ready);
endinterface

@@ rtl/core/piecewise_linear_envelope_top.sv @@
// Piecewise linear envelope: breakpoint table, knot walk and bit-serial interpolation divide.
// Depends on ple_pkg, ple_channels.sv and piecewise_linear_envelope_top_defines.svh.
//
//  channel    role     payload
//  request    sink     mode, position, level
//  response   source   amplitude, knot_accepted
//
//  Clear, append, unused mode and evaluate with fewer than two knots answer from idle.
//  Evaluate: the first read is issued on acceptance, the walk visits knots in turn on the
//  single read port of the table, then come a multiply, 17 divide steps, an add and output.
//  Held end values finish after the walk, without multiply or divide.
//  No clearing pass after reset; table entries are undefined until appended.
//  A stalled response holds the block in its output state; no new request is taken.
`include "piecewise_linear_envelope_top_defines.svh"

module piecewise_linear_envelope_top #(
    parameter int KNOT_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    ple_cmd_if.sink           request,
    ple_res_if.source         response
);

    localparam int W  = ple_pkg::VAL_W;
    localparam int IW = $clog2(KNOT_DEPTH);
    localparam int CW = $clog2(KNOT_DEPTH + 1);
    localparam int NW = ple_pkg::DIV_CNT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_ADD  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [NW-1:0]     step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [W-1:0]      out_amp_reg, out_amp_next;
    logic              out_acc_reg, out_acc_next;

    logic [W-1:0]      res_reg, res_next;
    logic [W-1:0]      t_reg, t_next;
    logic [W-1:0]      last_time_reg, last_time_next;
    logic [W-1:0]      prev_time_reg, prev_time_next;
    logic [W-1:0]      prev_lev_reg, prev_lev_next;
    logic [W-1:0]      dt_reg, dt_next;
    logic [W-1:0]      span_reg, span_next;
    logic [W-1:0]      diff_reg, diff_next;
    logic              dec_reg, dec_next;
    logic [2*W-1:0]    acc_reg, acc_next;

    logic [2*W-1:0]    knot_mem [KNOT_DEPTH];
    logic [2*W-1:0]    rdata_reg;
    logic [IW-1:0]     raddr;
    logic              wr_en;

    logic              accept_in;
    logic              out_free;
    logic              append_ok;
    logic [IW-1:0]     last_idx;
    logic [W-1:0]      cur_time;
    logic [W-1:0]      cur_lev;
    logic              past_knot;
    logic [2*W-1:0]    mul_prod;
    logic [W:0]        div_x;
    logic [W:0]        div_trial;
    logic              div_ge;
    logic [W-1:0]      rem_new;
    logic [2*W-1:0]    acc_step;

    assign out_free  = !out_valid_reg || response.ready;
    assign request.ready = (state_reg == S_IDLE) && out_free;
    assign accept_in = request.valid && request.ready;

    assign response.valid         = out_valid_reg;
    assign response.amplitude     = out_amp_reg;
    assign response.knot_accepted = out_acc_reg;

    assign append_ok = (request.position <= ple_pkg::UNIT_ONE)
                    && (request.level <= ple_pkg::UNIT_ONE)
                    && (count_reg < CW'(KNOT_DEPTH))
                    && ((count_reg == '0) || (request.position > last_time_reg));

    assign last_idx  = IW'(count_reg - CW'(1));
    assign cur_time  = rdata_reg[2*W-1:W];
    assign cur_lev   = rdata_reg[W-1:0];
    assign past_knot = t_reg > cur_time;

    assign mul_prod  = dt_reg * diff_reg;

    // Restoring divide step: remainder stays below span throughout
    assign div_x     = {acc_reg[2*W-1:W], acc_reg[W-1]};
    assign div_ge    = div_x >= {1'b0, span_reg};
    assign div_trial = div_x - {1'b0, span_reg};
    assign rem_new   = div_ge ? div_trial[W-1:0] : div_x[W-1:0];
    assign acc_step  = {rem_new, acc_reg[W-2:0], div_ge};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !response.ready;
        out_amp_next   = out_amp_reg;
        out_acc_next   = out_acc_reg;
        res_next       = res_reg;
        t_next         = t_reg;
        last_time_next = last_time_reg;
        prev_time_next = prev_time_reg;
        prev_lev_next  = prev_lev_reg;
        dt_next        = dt_reg;
        span_next      = span_reg;
        diff_next      = diff_reg;
        dec_next       = dec_reg;
        acc_next       = acc_reg;
        raddr          = idx_reg + IW'(1);
        wr_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                if (accept_in)
                begin
                    out_valid_next = 1'b1;
                    out_amp_next   = '0;
                    out_acc_next   = 1'b0;
                    case (request.mode)
                        ple_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ple_pkg::MODE_APPEND:
                        begin
                            out_acc_next = append_ok;
                            if (append_ok)
                            begin
                                wr_en          = 1'b1;
                                count_next     = count_reg + CW'(1);
                                last_time_next = request.position;
                            end
                        end
                        ple_pkg::MODE_EVAL:
                        begin
                            // Too few knots answers zero at once
                            if (count_reg >= CW'(2))
                            begin
                                out_valid_next = out_valid_reg && !response.ready;
                                t_next         = request.position;
                                idx_next       = '0;
                                state_next     = S_WALK;
                            end
                        end
                        default:
                        begin
                            out_acc_next = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (((idx_reg == '0) && !past_knot) || (past_knot && (idx_reg == last_idx)))
                begin
                    // Hold the end amplitude
                    res_next   = cur_lev;
                    state_next = S_DONE;
                end
                else if (past_knot)
                begin
                    prev_time_next = cur_time;
                    prev_lev_next  = cur_lev;
                    idx_next       = idx_reg + IW'(1);
                end
                else
                begin
                    dt_next    = t_reg - prev_time_reg;
                    span_next  = cur_time - prev_time_reg;
                    dec_next   = cur_lev < prev_lev_reg;
                    diff_next  = (cur_lev < prev_lev_reg) ? prev_lev_reg - cur_lev
                                                          : cur_lev - prev_lev_reg;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next   = mul_prod;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                acc_next  = acc_step;
                step_next = step_reg + NW'(1);
                if (step_reg == NW'(ple_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                res_next   = dec_reg ? prev_lev_reg - acc_reg[W-1:0]
                                     : prev_lev_reg + acc_reg[W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_amp_next   = res_reg;
                    out_acc_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_amp_reg   <= out_amp_next;
        out_acc_reg   <= out_acc_next;
        res_reg       <= res_next;
        t_reg         <= t_next;
        last_time_reg <= last_time_next;
        prev_time_reg <= prev_time_next;
        prev_lev_reg  <= prev_lev_next;
        dt_reg        <= dt_next;
        span_reg      <= span_next;
        diff_reg      <= diff_next;
        dec_reg       <= dec_next;
        acc_reg       <= acc_next;
    end

    // Knot table: time in the upper half, level in the lower half
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            knot_mem[count_reg[IW-1:0]] <= {request.position, request.level};
        end
        rdata_reg <= knot_mem[raddr];
    end

    `PLE_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CW'(KNOT_DEPTH), "knot count above table depth")
    `PLE_ASSERT_NEXT(a_append_count, wr_en, count_reg == $past(count_reg) + CW'(1), "stored knot did not advance count")
    `PLE_ASSERT_IMPLIES(a_rem_below_span, state_reg == S_DIV, acc_reg[2*W-1:W] < span_reg, "divide remainder not below span")
    `PLE_ASSERT_IMPLIES(a_quot_bound, state_reg == S_ADD, acc_reg[W-1:0] <= diff_reg, "quotient exceeds level step")

endmodule
